FILE: design/sesd_pkg.sv
package sesd_pkg;

    // fixed field widths
    localparam int SPEED_W  = 32;
    localparam int THR_W    = 24;
    localparam int DECEL_W  = 24;
    localparam int FLOOR_W  = 16;
    localparam int KW_W     = 11;
    localparam int FRAC_W   = 8;

    // raw speed is clipped at 2^RAW_Q in q.8
    localparam int RAW_Q    = 42;
    localparam int RAW_W    = RAW_Q + 1;

    localparam logic [KW_W-1:0] KW_ONE = 11'd1024;
    localparam int KW_SHIFT = 10;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_WEIGHT     = 2'd3;

    localparam logic [THR_W-1:0]   RST_SPEED_THRESHOLD = 24'd1100;
    localparam logic [DECEL_W-1:0] RST_DECEL_LIMIT     = 24'd9500;
    localparam logic [FLOOR_W-1:0] RST_NOISE_FLOOR     = 16'd50;
    localparam logic [KW_W-1:0]    RST_KEEP_WEIGHT     = 11'd717;

    // shift-subtract unit modes
    localparam logic MODE_DIV  = 1'b0;
    localparam logic MODE_SQRT = 1'b1;

endpackage

FILE: design/sesd_shsub.sv
module sesd_shsub
    import sesd_pkg::*;
#(
    parameter int SRC_W     = 50,
    parameter int U_W       = 65,
    parameter int MAX_STEPS = 42
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 mode,
    input  logic [SRC_W-1:0]                     src,
    input  logic [U_W-1:0]                       init_rem,
    input  logic [U_W-1:0]                       divisor,
    input  logic [$clog2(MAX_STEPS+1)-1:0]       steps,
    output logic                                 done,
    output logic [U_W-1:0]                       result
);

    localparam int STEP_W = $clog2(MAX_STEPS + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              mode_reg;
    logic [U_W-1:0]    rem_reg;
    logic [U_W-1:0]    res_reg;
    logic [U_W-1:0]    div_reg;
    logic [SRC_W-1:0]  src_reg;

    logic [U_W-1:0]    shifted;
    logic [U_W-1:0]    trial;
    logic [U_W:0]      diff;
    logic              ge;

    // one subtractor serves both the root and the long division
    always_comb
    begin
        if (mode_reg == MODE_SQRT)
        begin
            shifted = {rem_reg[U_W-3:0], src_reg[SRC_W-1:SRC_W-2]};
            trial   = {res_reg[U_W-3:0], 2'b01};
        end
        else
        begin
            shifted = {rem_reg[U_W-2:0], src_reg[SRC_W-1]};
            trial   = div_reg;
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        ge   = !diff[U_W];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= mode;
            rem_reg  <= init_rem;
            res_reg  <= '0;
            div_reg  <= divisor;
            src_reg  <= src;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[U_W-1:0] : shifted;
            res_reg <= {res_reg[U_W-2:0], ge};
            if (mode_reg == MODE_SQRT)
                src_reg <= src_reg << 2;
            else
                src_reg <= src_reg << 1;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: design/speed_ema_sudden_stop_detector.sv
// channel  | direction | handshake             | payload
// in       | input     | in_valid / in_stall   | pos_x, pos_y, pos_z, stamp
// out      | output    | out_valid / out_stall | speed, stop_detected
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// each frame runs a square root and then, unless the raw speed is capped, a long
// division on the shared shift-subtract unit; a frame with no usable time
// step skips both and goes straight to the output stage
// in_stall is high from acceptance until the result is loaded into the output
// register; a result waiting under out_stall holds the block only at its end
// reset clears the history and restores the register defaults; cfg_ready is
// always high
module speed_ema_sudden_stop_detector
    import sesd_pkg::*;
#(
    parameter int COORD_WIDTH      = 16,
    parameter int TIME_WIDTH       = 32,
    parameter int TICKS_PER_SECOND = 1000000
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic [TIME_WIDTH-1:0]         stamp,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [SPEED_W-1:0]            speed,
    output logic                          stop_detected,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [THR_W-1:0]              cfg_data
);

    localparam int CW      = COORD_WIDTH;
    localparam int TW      = TIME_WIDTH;
    localparam int SUM_W   = 2 * CW + 2;
    localparam int SQ_W    = SUM_W + 2 * FRAC_W;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int TPS_W   = $clog2(TICKS_PER_SECOND + 1);
    localparam int NUM_W   = ROOT_W + TPS_W;
    localparam int EXT_W   = (NUM_W > RAW_Q) ? NUM_W : RAW_Q + 1;
    localparam int CMP_W   = (EXT_W > TW + RAW_Q) ? EXT_W : TW + RAW_Q;
    localparam int U_A     = (ROOT_W + 2 > TW + 1) ? ROOT_W + 2 : TW + 1;
    localparam int U_W     = (U_A > RAW_Q) ? U_A : RAW_Q;
    localparam int SRC_W   = (SQ_W > RAW_Q) ? SQ_W : RAW_Q;
    localparam int MAX_ST  = (ROOT_W > RAW_Q) ? ROOT_W : RAW_Q;
    localparam int STEP_W  = $clog2(MAX_ST + 1);
    localparam int CH      = (ROOT_W + 1) / 2;
    localparam int H       = (TW + 1) / 2;
    localparam int EMA_W   = RAW_W + KW_W + 1;
    localparam int DA_W    = SPEED_W + TPS_W;
    localparam int DB_W    = SPEED_W + TW;
    localparam int DC_W    = (DA_W > DB_W) ? DA_W : DB_W;

    localparam logic [TPS_W-1:0] TPS_C = TPS_W'(TICKS_PER_SECOND);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SQ        = 4'd1;
    localparam logic [3:0] S_ROOT      = 4'd2;
    localparam logic [3:0] S_ROOT_WAIT = 4'd3;
    localparam logic [3:0] S_MUL_LO    = 4'd4;
    localparam logic [3:0] S_MUL_HI    = 4'd5;
    localparam logic [3:0] S_DIV_CHK   = 4'd6;
    localparam logic [3:0] S_DIV_WAIT  = 4'd7;
    localparam logic [3:0] S_EMA_MUL   = 4'd8;
    localparam logic [3:0] S_EMA_SUM   = 4'd9;
    localparam logic [3:0] S_STOP_A    = 4'd10;
    localparam logic [3:0] S_STOP_B    = 4'd11;
    localparam logic [3:0] S_STOP_CMP  = 4'd12;
    localparam logic [3:0] S_DONE      = 4'd13;

    logic [3:0]           state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;

    logic [THR_W-1:0]     thr_reg;
    logic [DECEL_W-1:0]   decel_reg;
    logic [FLOOR_W-1:0]   floor_reg;
    logic [KW_W-1:0]      kw_reg;

    logic [CW-1:0]        last_x_reg, last_y_reg, last_z_reg;
    logic [TW-1:0]        last_stamp_reg;
    logic [SPEED_W-1:0]   last_speed_reg;

    // frame payload
    logic [CW-1:0]        x_reg, y_reg, z_reg;
    logic [TW-1:0]        stamp_reg;
    logic [CW-1:0]        ax_reg, ay_reg, az_reg;
    logic [TW-1:0]        dt_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [ROOT_W-1:0]    dist_reg;
    logic [NUM_W-1:0]     prod_reg;
    logic [RAW_W-1:0]     raw_reg;
    logic [RAW_W-1:0]     pk_reg;
    logic [EMA_W-2:0]     pn_reg;
    logic [SPEED_W-1:0]   spd_reg;
    logic                 cond_reg;
    logic [DA_W-1:0]      da_reg;
    logic [DB_W-1:0]      db_reg;
    logic                 stop_reg;
    logic [SPEED_W-1:0]   speed_out_reg;
    logic                 stop_out_reg;

    logic                 in_acc;
    logic                 frame_ok;
    logic [CW:0]          dx, dy, dz;
    logic [CW-1:0]        mx, my, mz;
    logic [2*CW-1:0]      px, py, pz;
    logic [SUM_W-1:0]     sum_sq;
    logic [EXT_W-1:0]     n_ext;
    logic                 cap;
    logic [KW_W-1:0]      kw_sat;
    logic [EMA_W-1:0]     ema_sum;
    logic [EMA_W-KW_SHIFT-1:0] ema_acc;
    logic [SPEED_W-1:0]   ema_sat;
    logic [SPEED_W-1:0]   ema_gated;
    logic [SPEED_W-1:0]   decel_q;
    logic [SPEED_W+TW-H-1:0] db_hi;

    logic                 u_start;
    logic                 u_mode;
    logic [SRC_W-1:0]     u_src;
    logic [U_W-1:0]       u_init;
    logic [U_W-1:0]       u_div;
    logic [STEP_W-1:0]    u_steps;
    logic                 u_done;
    logic [U_W-1:0]       u_result;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign frame_ok = (last_stamp_reg != '0) && (stamp > last_stamp_reg);
    assign dx = {pos_x[CW-1], pos_x} - {last_x_reg[CW-1], last_x_reg};
    assign dy = {pos_y[CW-1], pos_y} - {last_y_reg[CW-1], last_y_reg};
    assign dz = {pos_z[CW-1], pos_z} - {last_z_reg[CW-1], last_z_reg};
    assign mx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    assign my = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    assign mz = dz[CW] ? CW'(-dz) : dz[CW-1:0];

    assign px     = ax_reg * ax_reg;
    assign py     = ay_reg * ay_reg;
    assign pz     = az_reg * az_reg;
    assign sum_sq = SUM_W'(px) + SUM_W'(py) + SUM_W'(pz);

    assign n_ext = EXT_W'(prod_reg);
    assign cap   = CMP_W'(n_ext) >= (CMP_W'(dt_reg) << RAW_Q);

    assign kw_sat    = (kw_reg > KW_ONE) ? KW_ONE : kw_reg;
    assign ema_sum   = EMA_W'(pk_reg) + EMA_W'(pn_reg);
    assign ema_acc   = ema_sum[EMA_W-1:KW_SHIFT];
    assign ema_sat   = (|ema_acc[EMA_W-KW_SHIFT-1:SPEED_W]) ? '1 : ema_acc[SPEED_W-1:0];
    assign ema_gated = (ema_sat < {floor_reg, 8'b0}) ? '0 : ema_sat;
    assign decel_q   = {decel_reg, 8'b0};
    assign db_hi     = decel_q * dt_reg[TW-1:H];

    // shared unit operands, left-aligned so bits leave msb first
    always_comb
    begin
        u_start = 1'b0;
        u_mode  = MODE_SQRT;
        u_src   = SRC_W'(sq_reg) << (SRC_W - SQ_W);
        u_init  = '0;
        u_div   = '0;
        u_steps = STEP_W'(ROOT_W);
        if (state_reg == S_ROOT)
            u_start = 1'b1;
        else if (state_reg == S_DIV_CHK)
        begin
            u_start = !cap;
            u_mode  = MODE_DIV;
            u_src   = SRC_W'(n_ext[RAW_Q-1:0]) << (SRC_W - RAW_Q);
            u_init  = U_W'(n_ext >> RAW_Q);
            u_div   = U_W'(dt_reg);
            u_steps = STEP_W'(RAW_Q);
        end
    end

    sesd_shsub #(
        .SRC_W     (SRC_W),
        .U_W       (U_W),
        .MAX_STEPS (MAX_ST)
    ) u_shsub (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (u_start),
        .mode     (u_mode),
        .src      (u_src),
        .init_rem (u_init),
        .divisor  (u_div),
        .steps    (u_steps),
        .done     (u_done),
        .result   (u_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:      if (in_acc) state_next = frame_ok ? S_SQ : S_DONE;
            S_SQ:        state_next = S_ROOT;
            S_ROOT:      state_next = S_ROOT_WAIT;
            S_ROOT_WAIT: if (u_done) state_next = S_MUL_LO;
            S_MUL_LO:    state_next = S_MUL_HI;
            S_MUL_HI:    state_next = S_DIV_CHK;
            S_DIV_CHK:   state_next = cap ? S_EMA_MUL : S_DIV_WAIT;
            S_DIV_WAIT:  if (u_done) state_next = S_EMA_MUL;
            S_EMA_MUL:   state_next = S_EMA_SUM;
            S_EMA_SUM:   state_next = S_STOP_A;
            S_STOP_A:    state_next = S_STOP_B;
            S_STOP_B:    state_next = S_STOP_CMP;
            S_STOP_CMP:  state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            thr_reg        <= RST_SPEED_THRESHOLD;
            decel_reg      <= RST_DECEL_LIMIT;
            floor_reg      <= RST_NOISE_FLOOR;
            kw_reg         <= RST_KEEP_WEIGHT;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            last_z_reg     <= '0;
            last_stamp_reg <= '0;
            last_speed_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SPEED_THRESHOLD: thr_reg   <= cfg_data;
                    CFG_DECEL_LIMIT:     decel_reg <= cfg_data;
                    CFG_NOISE_FLOOR:     floor_reg <= cfg_data[FLOOR_W-1:0];
                    CFG_KEEP_WEIGHT:     kw_reg    <= cfg_data[KW_W-1:0];
                endcase
            end
            // history moves on once the result is handed over
            if (state_reg == S_DONE && state_next == S_IDLE)
            begin
                last_x_reg     <= x_reg;
                last_y_reg     <= y_reg;
                last_z_reg     <= z_reg;
                last_stamp_reg <= stamp_reg;
                last_speed_reg <= spd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    x_reg     <= pos_x;
                    y_reg     <= pos_y;
                    z_reg     <= pos_z;
                    stamp_reg <= stamp;
                    ax_reg    <= mx;
                    ay_reg    <= my;
                    az_reg    <= mz;
                    dt_reg    <= stamp - last_stamp_reg;
                    spd_reg   <= '0;
                    stop_reg  <= 1'b0;
                end
            end
            S_SQ:        sq_reg <= {sum_sq, 16'b0};
            S_ROOT_WAIT: if (u_done) dist_reg <= u_result[ROOT_W-1:0];
            S_MUL_LO:    prod_reg <= NUM_W'(dist_reg[CH-1:0] * TPS_C);
            S_MUL_HI:    prod_reg <= prod_reg
                                     + (NUM_W'(dist_reg[ROOT_W-1:CH] * TPS_C) << CH);
            S_DIV_CHK:   if (cap) raw_reg <= RAW_W'(1) << RAW_Q;
            S_DIV_WAIT:  if (u_done) raw_reg <= RAW_W'(u_result[RAW_Q-1:0]);
            S_EMA_MUL:
            begin
                pk_reg <= RAW_W'(kw_sat * last_speed_reg);
                pn_reg <= (EMA_W-1)'((KW_ONE - kw_sat) * raw_reg);
            end
            S_EMA_SUM:   spd_reg <= ema_gated;
            S_STOP_A:
            begin
                cond_reg <= (last_speed_reg > {thr_reg, 8'b0}) && (last_speed_reg > spd_reg);
                da_reg   <= DA_W'((last_speed_reg - spd_reg) * TPS_C);
                db_reg   <= DB_W'(decel_q * dt_reg[H-1:0]);
            end
            S_STOP_B:    db_reg <= db_reg + (DB_W'(db_hi) << H);
            S_STOP_CMP:  stop_reg <= cond_reg && (DC_W'(da_reg) > DC_W'(db_reg));
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    speed_out_reg <= spd_reg;
                    stop_out_reg  <= stop_reg;
                end
            end
            default:     ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign speed         = speed_out_reg;
    assign stop_detected = stop_out_reg;

endmodule

FILE: design/sesd_checker.sv
module sesd_checker
    import sesd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [SPEED_W-1:0] speed,
    input  logic               stop_detected,
    input  logic               cfg_ready
);

    // one frame at a time: after a beat is taken the input closes
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open right after an accepted beat");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

    // a stop needs the speed to fall below the previous one
    a_stop_not_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stop_detected) |-> (speed != '1))
        else $error("stop flagged with saturated speed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(speed) && $stable(stop_detected)))
        else $error("stalled output beat changed");

endmodule

bind speed_ema_sudden_stop_detector sesd_checker u_sesd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .speed         (speed),
    .stop_detected (stop_detected),
    .cfg_ready     (cfg_ready)
);
